### rtl/tof_ranging_result_processor_macros.svh
// Assertion macros shared by the ranging result processor RTL.
`ifndef TOF_RANGING_RESULT_PROCESSOR_MACROS_SVH
`define TOF_RANGING_RESULT_PROCESSOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define TOFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define TOFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tofr_pkg.sv
// Types, constants and the status mapping of the ranging result processor.
package tofr_pkg;

    // Range scale: raw * 2011 / 0x800, rounded by adding 0x400 first.
    localparam logic [10:0] RANGE_SCALE = 11'd2011;
    localparam logic [10:0] RANGE_HALF  = 11'h400;
    localparam int          RANGE_SHIFT = 11;
    localparam int          PROD_W      = 27;

    localparam logic [15:0] TARGET_RATE_RESET = 16'h0A00;
    localparam logic [15:0] SPAD_FALLBACK     = 16'h8000;
    localparam logic [15:0] SAT16             = 16'hFFFF;

    // Quotient bits produced by the two divider chains.
    localparam int DIV1_STEPS = 32;
    localparam int DIV2_STEPS = 16;

    // Raw device status codes.
    localparam logic [7:0] RAW_HW_A     = 8'd1;
    localparam logic [7:0] RAW_HW_B     = 8'd2;
    localparam logic [7:0] RAW_HW_C     = 8'd3;
    localparam logic [7:0] RAW_SIGNAL   = 8'd4;
    localparam logic [7:0] RAW_BOUNDS   = 8'd5;
    localparam logic [7:0] RAW_SIGMA    = 8'd6;
    localparam logic [7:0] RAW_WRAP     = 8'd7;
    localparam logic [7:0] RAW_MINCLIP  = 8'd8;
    localparam logic [7:0] RAW_NOWRAP   = 8'd9;
    localparam logic [7:0] RAW_XTALK    = 8'd12;
    localparam logic [7:0] RAW_MINRANGE = 8'd13;
    localparam logic [7:0] RAW_HW_D     = 8'd17;
    localparam logic [7:0] RAW_SYNC     = 8'd18;

    // Dense status codes.
    localparam logic [3:0] ST_VALID    = 4'd0;
    localparam logic [3:0] ST_SIGMA    = 4'd1;
    localparam logic [3:0] ST_SIGNAL   = 4'd2;
    localparam logic [3:0] ST_MINCLIP  = 4'd3;
    localparam logic [3:0] ST_BOUNDS   = 4'd4;
    localparam logic [3:0] ST_HW       = 4'd5;
    localparam logic [3:0] ST_NOWRAP   = 4'd6;
    localparam logic [3:0] ST_WRAP     = 4'd7;
    localparam logic [3:0] ST_XTALK    = 4'd8;
    localparam logic [3:0] ST_SYNC     = 4'd9;
    localparam logic [3:0] ST_MINRANGE = 4'd10;
    localparam logic [3:0] ST_NONE     = 4'd11;

    // Payload carried by every stage of the divider chain.
    typedef struct packed {
        logic [15:0] range_val;
        logic [3:0]  status_code;
        logic        fb;        // result is the fallback SPAD count
        logic        sat;       // result saturates to 0xFFFF
        logic [15:0] target;
        logic [31:0] rem;
        logic [31:0] divisor;
        logic [31:0] dvd;       // dividend bits still to be shifted in, MSB first
        logic [31:0] quo;
    } tofr_cell_t;

    function automatic logic [3:0] map_status(input logic [7:0] raw,
                                              input logic [7:0] stream);
        logic [3:0] code;
        case (raw)
            RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D: code = ST_HW;
            RAW_SIGNAL:   code = ST_SIGNAL;
            RAW_BOUNDS:   code = ST_BOUNDS;
            RAW_SIGMA:    code = ST_SIGMA;
            RAW_WRAP:     code = ST_WRAP;
            RAW_MINCLIP:  code = ST_MINCLIP;
            RAW_NOWRAP:   code = (stream == 8'd0) ? ST_NOWRAP : ST_VALID;
            RAW_XTALK:    code = ST_XTALK;
            RAW_MINRANGE: code = ST_MINRANGE;
            RAW_SYNC:     code = ST_SYNC;
            default:      code = ST_NONE;
        endcase
        return code;
    endfunction

endpackage

### rtl/tofr_div_cell.sv
// One restoring-division cell: produces one quotient bit per stage.
`include "tof_ranging_result_processor_macros.svh"

module tofr_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  tofr_pkg::tofr_cell_t in_dat,
    output logic               out_vld,
    output tofr_pkg::tofr_cell_t out_dat
);
    import tofr_pkg::*;

    logic        vld_reg;
    tofr_cell_t  dat_reg;
    tofr_cell_t  dat_next;
    logic [32:0] shifted;
    logic [33:0] trial;
    logic        ge;

    always_comb
    begin
        shifted  = {in_dat.rem, in_dat.dvd[31]};
        trial    = {1'b0, shifted} - {2'b00, in_dat.divisor};
        ge       = !trial[33];
        dat_next = in_dat;
        dat_next.rem = ge ? trial[31:0] : shifted[31:0];
        dat_next.dvd = {in_dat.dvd[30:0], 1'b0};
        dat_next.quo = {in_dat.quo[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dat_reg <= dat_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_dat = dat_reg;

    `TOFR_ASSERT_NOW(a_rem_below_divisor, vld_reg && (dat_reg.divisor != 32'd0), dat_reg.rem < dat_reg.divisor, "partial remainder reached the divisor")

endmodule

### rtl/tofr_mid.sv
// Turn stage between the two divider chains: flags special cases, loads the second division.
module tofr_mid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  tofr_pkg::tofr_cell_t in_dat,
    output logic               out_vld,
    output tofr_pkg::tofr_cell_t out_dat
);
    import tofr_pkg::*;

    logic        vld_reg;
    tofr_cell_t  dat_reg;
    tofr_cell_t  dat_next;
    logic [31:0] per_spad;
    logic [31:0] target_ext;
    logic        fb;
    logic        sat;

    always_comb
    begin
        per_spad   = in_dat.quo;
        target_ext = {16'd0, in_dat.target};
        fb         = in_dat.fb || (per_spad == 32'd0);
        // The quotient overflows 16 bits exactly when target >= rate per SPAD.
        sat        = target_ext >= per_spad;
        dat_next         = in_dat;
        dat_next.fb      = fb;
        dat_next.sat     = sat;
        dat_next.rem     = (fb || sat) ? 32'd0 : target_ext;
        dat_next.divisor = per_spad;
        dat_next.dvd     = 32'd0;
        dat_next.quo     = 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dat_reg <= dat_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_dat = dat_reg;

endmodule

### rtl/tof_ranging_result_processor.sv
// Top level of the time-of-flight ranging result processor.
//
//  Channel   Direction  Signals                              Contents
//  s_axis    in         s_tvalid s_tready s_tdata[79:0]      one raw ranging result
//  m_axis    out        m_tvalid m_tready m_tdata[39:0]      range, status, SPAD selection
//  cfg       in         cfg_we cfg_wdata[15:0]               target_rate register
//
// One transaction is accepted per clock cycle when the output side keeps up. Every
// input transaction yields exactly one output transaction. The path from input to
// output runs through the divider chain: an input stage, 32 cells for the rate per
// SPAD, one turn stage, 16 cells for the SPAD selection, and the output register.
// rst_n is asynchronous and active low; it clears all valid flags and sets
// target_rate to 0x0A00. When the output stalls, one more result lands in a skid
// register; only while that register is full does s_tready drop and the chain hold.
`include "tof_ranging_result_processor_macros.svh"

module tof_ranging_result_processor (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: target_rate written when cfg_we is high.
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] raw_status, [15:8] stream_cnt, [31:16] effective_spads,
    // [47:32] ambient_rate, [63:48] peak_rate, [79:64] raw_range
    input  logic [79:0] s_tdata,
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] range_val, [19:16] status_code, [35:20] spad_select, [39:36] zero
    output logic [39:0] m_tdata
);
    import tofr_pkg::*;

    logic [15:0] target_reg;

    // Input fields.
    logic [7:0]  raw_status;
    logic [7:0]  stream_cnt;
    logic [15:0] effective_spads;
    logic [15:0] ambient_rate;
    logic [15:0] peak_rate;
    logic [15:0] raw_range;

    // Input stage.
    logic [PROD_W-1:0] range_prod;
    logic [PROD_W-1:0] range_round;
    logic [16:0]       rate_sum;
    logic [15:0]       rate_sat;
    tofr_cell_t        s0_next;
    tofr_cell_t        s0_reg;
    logic              s0_vld_reg;

    // Divider chains.
    logic       [DIV1_STEPS:0] d1_vld;
    tofr_cell_t                d1_dat [DIV1_STEPS+1];
    logic       [DIV2_STEPS:0] d2_vld;
    tofr_cell_t                d2_dat [DIV2_STEPS+1];

    // Output side.
    logic        adv;
    logic        take;
    logic        push;
    logic        fin_vld;
    tofr_cell_t  fin_dat;
    logic [15:0] spad_select;
    logic [39:0] fin_tdata;
    logic        out_vld_reg;
    logic [39:0] out_data_reg;
    logic        skid_vld_reg;
    logic [39:0] skid_data_reg;

    // The whole chain moves as long as the skid register is free.
    assign adv      = !skid_vld_reg;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RATE_RESET;
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_wdata;
        end
    end

    assign raw_status      = s_tdata[7:0];
    assign stream_cnt      = s_tdata[15:8];
    assign effective_spads = s_tdata[31:16];
    assign ambient_rate    = s_tdata[47:32];
    assign peak_rate       = s_tdata[63:48];
    assign raw_range       = s_tdata[79:64];

    // Input stage: scaled range, status mapping and the setup of the first division,
    // which computes (saturated rate sum << 16) / effective_spads.
    always_comb
    begin
        range_prod  = PROD_W'(raw_range) * PROD_W'(RANGE_SCALE);
        range_round = range_prod + PROD_W'(RANGE_HALF);
        rate_sum    = {1'b0, peak_rate} + {1'b0, ambient_rate};
        rate_sat    = rate_sum[16] ? SAT16 : rate_sum[15:0];

        s0_next.range_val   = range_round[RANGE_SHIFT +: 16];
        s0_next.status_code = map_status(raw_status, stream_cnt);
        s0_next.fb          = (effective_spads == 16'd0);
        s0_next.sat         = 1'b0;
        s0_next.target      = target_reg;
        s0_next.rem         = 32'd0;
        s0_next.divisor     = {16'd0, effective_spads};
        s0_next.dvd         = {rate_sat, 16'd0};
        s0_next.quo         = 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= s0_next;
        end
    end

    // First chain: one quotient bit of the rate per SPAD per cell.
    assign d1_vld[0] = s0_vld_reg;
    assign d1_dat[0] = s0_reg;

    for (genvar i = 0; i < DIV1_STEPS; i++)
    begin : g_div1
        tofr_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (d1_vld[i]),
            .in_dat  (d1_dat[i]),
            .out_vld (d1_vld[i+1]),
            .out_dat (d1_dat[i+1])
        );
    end

    // Turn stage: fallback and saturation checks, then (target << 16) / rate per SPAD.
    tofr_mid u_mid (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (d1_vld[DIV1_STEPS]),
        .in_dat  (d1_dat[DIV1_STEPS]),
        .out_vld (d2_vld[0]),
        .out_dat (d2_dat[0])
    );

    // Second chain: only the low 16 quotient bits are needed once saturation is known.
    for (genvar j = 0; j < DIV2_STEPS; j++)
    begin : g_div2
        tofr_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (d2_vld[j]),
            .in_dat  (d2_dat[j]),
            .out_vld (d2_vld[j+1]),
            .out_dat (d2_dat[j+1])
        );
    end

    assign fin_vld = d2_vld[DIV2_STEPS];
    assign fin_dat = d2_dat[DIV2_STEPS];

    always_comb
    begin
        if (fin_dat.fb)
        begin
            spad_select = SPAD_FALLBACK;
        end
        else if (fin_dat.sat)
        begin
            spad_select = SAT16;
        end
        else
        begin
            spad_select = fin_dat.quo[15:0];
        end
        fin_tdata = {4'd0, spad_select, fin_dat.status_code, fin_dat.range_val};
    end

    // Output register with a one-entry skid register behind it.
    assign take = out_vld_reg && m_tready;
    assign push = adv && fin_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || take)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= push;
            end
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || take)
        begin
            if (skid_vld_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= fin_tdata;
            end
        end
        else if (push)
        begin
            skid_data_reg <= fin_tdata;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    `TOFR_ASSERT_NOW(a_skid_behind_out, skid_vld_reg, out_vld_reg, "skid full, output empty")
    `TOFR_ASSERT_NEXT(a_chain_holds, skid_vld_reg, $stable(fin_vld), "chain moved while held")
    `TOFR_ASSERT_NEXT(a_result_kept, out_vld_reg && !m_tready, out_vld_reg, "stalled result lost")

endmodule

### sim/tofr_result_checker.sv
// Scoreboard that predicts and checks every output transaction of the ranging processor.
`timescale 1ns / 100ps

module tofr_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatches,
    output int          outstanding
);
    import tofr_pkg::*;

    typedef struct packed {
        logic [15:0] range_val;
        logic [3:0]  status_code;
        logic [15:0] spad_select;
    } ranging_result_t;

    ranging_result_t expected_results[$];
    logic [15:0]     target_rate_copy;

    function automatic ranging_result_t predict_result(input logic [79:0] reading,
                                                       input logic [15:0] target);
        logic [7:0]      raw_status;
        logic [7:0]      stream_cnt;
        logic [15:0]     spads;
        logic [15:0]     ambient;
        logic [15:0]     peak;
        logic [15:0]     raw_range;
        logic [31:0]     scaled;
        logic [16:0]     rate_sum;
        logic [15:0]     sat_sum;
        logic [31:0]     per_spad;
        logic [31:0]     need;
        ranging_result_t r;
        raw_status   = reading[7:0];
        stream_cnt   = reading[15:8];
        spads        = reading[31:16];
        ambient      = reading[47:32];
        peak         = reading[63:48];
        raw_range    = reading[79:64];

        // Rounded scale by 2011/2048; the product fits in 27 bits.
        scaled      = 32'(raw_range) * 32'd2011 + 32'h400;
        r.range_val = scaled[26:11];

        case (raw_status)
            RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D: r.status_code = ST_HW;
            RAW_SIGNAL:   r.status_code = ST_SIGNAL;
            RAW_BOUNDS:   r.status_code = ST_BOUNDS;
            RAW_SIGMA:    r.status_code = ST_SIGMA;
            RAW_WRAP:     r.status_code = ST_WRAP;
            RAW_MINCLIP:  r.status_code = ST_MINCLIP;
            RAW_NOWRAP:   r.status_code = (stream_cnt == 8'd0) ? ST_NOWRAP : ST_VALID;
            RAW_XTALK:    r.status_code = ST_XTALK;
            RAW_MINRANGE: r.status_code = ST_MINRANGE;
            RAW_SYNC:     r.status_code = ST_SYNC;
            default:      r.status_code = ST_NONE;
        endcase

        if (spads == 16'd0)
        begin
            r.spad_select = SPAD_FALLBACK;
        end
        else
        begin
            rate_sum = {1'b0, ambient} + {1'b0, peak};
            sat_sum  = rate_sum[16] ? SAT16 : rate_sum[15:0];
            per_spad = {sat_sum, 16'h0000} / {16'h0000, spads};
            if (per_spad == 32'd0)
            begin
                r.spad_select = SPAD_FALLBACK;
            end
            else
            begin
                need          = {target, 16'h0000} / per_spad;
                r.spad_select = (need[31:16] != 16'd0) ? SAT16 : need[15:0];
            end
        end
        return r;
    endfunction

    // Shadow of the target rate register.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_rate_copy <= TARGET_RATE_RESET;
        else if (cfg_we)
            target_rate_copy <= cfg_wdata;
    end

    always @(posedge clk)
    begin
        ranging_result_t got;
        ranging_result_t want;
        if (!rst_n)
        begin
            mismatches  = 0;
            outstanding = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[15:0], m_tdata[19:16], m_tdata[35:20]};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected output transaction, expected none got %h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.range_val !== want.range_val)
                    begin
                        $display("%0t: range_val expected %h got %h",
                                 $time, want.range_val, got.range_val);
                        mismatches++;
                    end
                    if (got.status_code !== want.status_code)
                    begin
                        $display("%0t: status_code expected %0d got %0d",
                                 $time, want.status_code, got.status_code);
                        mismatches++;
                    end
                    if (got.spad_select !== want.spad_select)
                    begin
                        $display("%0t: spad_select expected %h got %h",
                                 $time, want.spad_select, got.spad_select);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_result(s_tdata, target_rate_copy));
            outstanding = expected_results.size();
        end
    end

endmodule

### sim/tb.sv
// Stimulus and verdict for the time-of-flight ranging result processor.
`timescale 1ns / 100ps

module tb;
    import tofr_pkg::*;

    // The run is aborted after this many cycles.
    localparam int CYCLE_LIMIT = 200000;
    // Phases of random transactions, each under its own target rate.
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 116;
    // Cycles waited after the last result, somewhat more than the pipeline depth.
    localparam int DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    // While set, neither side idles; this gives one long back-to-back stretch.
    bit          steady = 1'b0;

    // Raw status bytes that the block decodes; random picks favor these.
    logic [7:0]  known_status[14] = '{RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D, RAW_SIGNAL,
                                      RAW_BOUNDS, RAW_SIGMA, RAW_WRAP, RAW_MINCLIP,
                                      RAW_NOWRAP, RAW_NOWRAP, RAW_XTALK, RAW_MINRANGE,
                                      RAW_SYNC};

    tof_ranging_result_processor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tofr_result_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The output side stalls at random with a probability of 13 percent, except during the steady stretch.
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 13);
    end

    // Offers one raw ranging result and holds it until the block takes the transaction.
    // Returns at the falling edge after acceptance, with tvalid still high so that
    // the next call can keep it up without a glitch.
    task automatic send_reading(input logic [7:0] raw_status, input logic [7:0] stream_cnt,
                                input logic [15:0] spads, input logic [15:0] ambient,
                                input logic [15:0] peak, input logic [15:0] raw_range);
        while (!steady && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_range, peak, ambient, spads, stream_cnt, raw_status};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the input side idle until the scoreboard has seen every expected result.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_target_rate(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Rates and SPAD counts: zero, all ones, small, medium and full range values,
    // so that fallback, saturation and ordinary quotients all occur.
    function automatic logic [15:0] pick_rate_or_count();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(1, 255));
            4, 5:    return 16'($urandom_range(256, 4095));
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic send_random_reading();
        logic [7:0] raw_status;
        logic [7:0] stream_cnt;
        if ($urandom_range(99) < 65)
            raw_status = known_status[$urandom_range(13)];
        else
            raw_status = 8'($urandom_range(255));
        stream_cnt = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
        send_reading(raw_status, stream_cnt, pick_rate_or_count(), pick_rate_or_count(),
                     pick_rate_or_count(), 16'($urandom_range(16'hFFFF)));
    endtask

    initial
    begin
        logic [15:0] phase_rate[PHASES];
        phase_rate = '{16'hFFFF, 16'h0000, 16'($urandom_range(16'hFFFF)), 16'h0001,
                       TARGET_RATE_RESET, 16'($urandom_range(16'hFFFF)), 16'h8000,
                       16'($urandom_range(1, 16'h00FF))};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed transactions under the reset target rate. Every decoded status
        // appears, the no-wrap case with a zero and a nonzero stream count, and
        // unknown bytes at both ends of the range. The numeric corners: zero SPAD
        // count, a saturated rate sum, a zero rate per SPAD (zero signal), a SPAD
        // count that saturates, and the range at both extremes.
        send_reading(RAW_HW_A,     8'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_reading(RAW_HW_B,     8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(RAW_HW_C,     8'd1,   16'h0100, 16'h0000, 16'h0000, 16'h0001);
        send_reading(RAW_HW_D,     8'd0,   16'hFFFF, 16'h0000, 16'h0001, 16'h0002);
        send_reading(RAW_SIGNAL,   8'd0,   16'h0100, 16'h0000, 16'h0A00, 16'd1023);
        send_reading(RAW_BOUNDS,   8'd7,   16'h0001, 16'h8000, 16'h8000, 16'd1024);
        send_reading(RAW_SIGMA,    8'hAA,  16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA);
        send_reading(RAW_WRAP,     8'h55,  16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555);
        send_reading(RAW_MINCLIP,  8'd128, 16'h8000, 16'h0001, 16'h0000, 16'h8000);
        send_reading(RAW_NOWRAP,   8'd0,   16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF);
        send_reading(RAW_NOWRAP,   8'd1,   16'h0200, 16'h0010, 16'h0300, 16'd2048);
        send_reading(RAW_NOWRAP,   8'd255, 16'h7FFF, 16'h0000, 16'h0001, 16'd3000);
        send_reading(RAW_XTALK,    8'd3,   16'h0040, 16'h0100, 16'h0100, 16'd100);
        send_reading(RAW_MINRANGE, 8'd0,   16'h1000, 16'h0000, 16'h0000, 16'd1);
        send_reading(RAW_SYNC,     8'd9,   16'h0001, 16'h0000, 16'hFFFF, 16'd65000);
        send_reading(8'd0,         8'd0,   16'h0300, 16'h0200, 16'h0500, 16'd1500);
        send_reading(8'hFF,        8'hFF,  16'h0800, 16'h4000, 16'h0400, 16'd40000);
        send_reading(8'd10,        8'd2,   16'h0002, 16'hFFFE, 16'h0001, 16'd12345);
        send_reading(8'd16,        8'd0,   16'h0001, 16'h0001, 16'h0000, 16'd7);
        send_reading(8'd19,        8'd4,   16'h00C0, 16'h0020, 16'h0E00, 16'd500);

        // Random phases. The register is written only once the pipeline is empty,
        // since every transaction yields a result, an empty scoreboard means idle.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_drain();
            write_target_rate(phase_rate[p]);
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // In the middle of phase 4, the sender holds off once until everything has come back.
                if (p == 4 && n == PHASE_ITEMS / 2)
                    wait_for_drain();
                send_random_reading();
            end
            steady = 1'b0;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
